@@ hw/rtl/jhls_pkg.sv @@
package jhls_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int OFFSET_WIDTH_MAX = 32;
    localparam int HDR_WIDTH        = 24;
    localparam int STATUS_WIDTH     = 3;

    localparam logic [7:0] MARK_BYTE = 8'hFF;
    localparam logic [7:0] TAG_SOI   = 8'hD8;
    localparam logic [7:0] TAG_APP0  = 8'hE0;
    localparam logic [7:0] TAG_DQT   = 8'hDB;

    localparam logic [STATUS_WIDTH-1:0] ST_FOUND      = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_MARKER = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_SOI    = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_APP0   = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_EARLY_END  = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_LENGTH = 3'd5;

    typedef logic [STATUS_WIDTH-1:0] t_status;
    typedef logic [HDR_WIDTH-1:0]    t_hdr;

endpackage

@@ hw/rtl/jhls_in_if.sv @@
interface jhls_in_if;
    import jhls_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_file;
    logic       end_of_file;

    modport source (output valid, output data_byte, output first_of_file,
                    output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input first_of_file,
                    input end_of_file, output ready);
endinterface

@@ hw/rtl/jhls_out_if.sv @@
interface jhls_out_if;
    import jhls_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_hdr    header_bytes;

    modport source (output valid, output status, output header_bytes, input ready);
    modport sink   (input valid, input status, input header_bytes, output ready);
endinterface

@@ hw/rtl/jpeg_header_length_scanner_top.sv @@
// Marker segment scanner for a JPEG byte stream.
// Input channel i_in: one file byte per word, with first_of_file marking
// byte 0 of a file (restarts the scan) and end_of_file marking the last byte.
// The scan checks FF D8, FF E0, then walks length-prefixed segments until a
// marker with tag DB; it reports that marker's FF offset or an error code.
// Output channel o_out: at most one word per file, status and header_bytes.
// Throughput: one byte per cycle. Each byte goes through the phase/offset
// update in the cycle it is accepted; a result word is registered and shows
// on o_out in the cycle after the byte that caused it.
// Bytes outside a scan (no first_of_file seen since the last result) are
// consumed and dropped.
// Reset (i_rst_n low, synchronous) idles the scanner and empties the output
// register. When the receiver stalls with a result word pending, the word
// holds and i_in.ready drops until it is taken; while o_out.ready is high,
// a byte is accepted in the same cycle the pending word leaves.
module jpeg_header_length_scanner_top #(
    parameter int OFFSET_WIDTH = jhls_pkg::OFFSET_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jhls_in_if.sink     i_in,
    jhls_out_if.source  o_out
);
    import jhls_pkg::*;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_SOI_FF  = 4'd1;
    localparam logic [3:0] PH_SOI_TAG = 4'd2;
    localparam logic [3:0] PH_APP_FF  = 4'd3;
    localparam logic [3:0] PH_APP_TAG = 4'd4;
    localparam logic [3:0] PH_LEN_HI  = 4'd5;
    localparam logic [3:0] PH_LEN_LO  = 4'd6;
    localparam logic [3:0] PH_SKIP    = 4'd7;
    localparam logic [3:0] PH_MK_FF   = 4'd8;
    localparam logic [3:0] PH_MK_TAG  = 4'd9;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam logic [OFFSET_WIDTH_MAX-1:0] HDR_MAX =
        OFFSET_WIDTH_MAX'((64'd1 << HDR_WIDTH) - 64'd1);

    logic [3:0]              r_phase,  n_phase;
    logic [OFFSET_WIDTH-1:0] r_off,    n_off;
    logic [15:0]             r_skip,   n_skip;
    logic [7:0]              r_len_hi, n_len_hi;
    logic                    r_o_valid;
    t_status                 r_status, n_status;
    t_hdr                    r_hdr,    n_hdr;

    logic                    accept;
    logic                    emit;
    logic [3:0]              cur_phase;
    logic [OFFSET_WIDTH-1:0] cur_off;
    logic [OFFSET_WIDTH-1:0] mk_off;
    logic [OFFSET_WIDTH_MAX-1:0] mk_off_ext;
    logic [15:0]             seg_len;

    assign i_in.ready = !r_o_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign cur_phase = i_in.first_of_file ? PH_SOI_FF : r_phase;
    assign cur_off   = i_in.first_of_file ? '0 : r_off;
    assign seg_len   = {(i_in.first_of_file ? 8'd0 : r_len_hi), i_in.data_byte};

    // offset of the FF just before this tag byte
    always_comb begin
        if (cur_off == OFF_MAX) begin
            mk_off = OFF_MAX;
        end else if (cur_off != '0) begin
            mk_off = cur_off - 1'b1;
        end else begin
            mk_off = '0;
        end
        mk_off_ext = OFFSET_WIDTH_MAX'(mk_off);
    end

    always_comb begin
        n_phase  = cur_phase;
        n_off    = cur_off;
        n_skip   = i_in.first_of_file ? 16'd0 : r_skip;
        n_len_hi = i_in.first_of_file ? 8'd0 : r_len_hi;
        emit     = 1'b0;
        n_status = ST_FOUND;
        n_hdr    = '0;

        if (cur_phase != PH_IDLE) begin
            case (cur_phase)
                PH_SOI_FF, PH_APP_FF, PH_MK_FF: begin
                    if (i_in.data_byte != MARK_BYTE) begin
                        emit     = 1'b1;
                        n_status = ST_NOT_MARKER;
                    end else begin
                        n_phase = cur_phase + 4'd1;
                    end
                end
                PH_SOI_TAG: begin
                    if (i_in.data_byte != TAG_SOI) begin
                        emit     = 1'b1;
                        n_status = ST_NOT_SOI;
                    end else begin
                        n_phase = PH_APP_FF;
                    end
                end
                PH_APP_TAG: begin
                    if (i_in.data_byte != TAG_APP0) begin
                        emit     = 1'b1;
                        n_status = ST_NOT_APP0;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_len_hi = i_in.data_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (seg_len[15:1] == 15'd0) begin
                        emit     = 1'b1;
                        n_status = ST_BAD_LENGTH;
                    end else begin
                        n_skip  = seg_len - 16'd2;
                        n_phase = (seg_len == 16'd2) ? PH_MK_FF : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (n_skip != 16'd0) begin
                        n_skip = n_skip - 16'd1;
                    end
                    if (n_skip == 16'd0) begin
                        n_phase = PH_MK_FF;
                    end
                end
                PH_MK_TAG: begin
                    if (i_in.data_byte == TAG_DQT) begin
                        emit     = 1'b1;
                        n_status = ST_FOUND;
                        n_hdr    = (mk_off_ext > HDR_MAX) ? HDR_MAX[HDR_WIDTH-1:0]
                                                          : mk_off_ext[HDR_WIDTH-1:0];
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (!emit && i_in.end_of_file && n_phase != PH_IDLE) begin
                emit     = 1'b1;
                n_status = ST_EARLY_END;
                n_hdr    = '0;
            end
            if (emit) begin
                n_phase = PH_IDLE;
            end
            if (cur_off != OFF_MAX) begin
                n_off = cur_off + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_off     <= '0;
            r_skip    <= '0;
            r_len_hi  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_off     <= n_off;
                r_skip    <= n_skip;
                r_len_hi  <= n_len_hi;
                r_o_valid <= emit;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_status <= n_status;
            r_hdr    <= n_hdr;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_status;
    assign o_out.header_bytes = r_hdr;

endmodule
